// File: rtl/core/smg_pkg.sv
// shared types and constants of the seeded mulberry32 generator
package smg_pkg;

    localparam logic [31:0] GOLDEN_MUL = 32'h9e37_79b9;
    localparam logic [31:0] MIX_MUL_A  = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_MUL_B  = 32'hc2b2_ae35;
    localparam logic [31:0] WEYL_STEP  = 32'h6d2b_79f5;
    localparam logic [31:0] TEMPER_OR  = 32'd61;
    localparam logic [7:0]  BOOT_BYTE  = 8'h30;

    localparam logic [1:0] MODE_ABSORB = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_DRAW   = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ABS_MUL,
        DP_ABS_LOAD,
        DP_FIN_MUL_A,
        DP_FIN_MUL_B,
        DP_FIN_LOAD,
        DP_DRAW_STEP,
        DP_DRAW_MUL_A,
        DP_DRAW_MUL_B,
        DP_DRAW_OUT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        logic   boot_byte;
        dp_op_t op;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_ABS_MUL,
        S_ABS_LOAD,
        S_FIN_MUL_A,
        S_FIN_MUL_B,
        S_FIN_LOAD,
        S_DRAW_STEP,
        S_DRAW_MUL_A,
        S_DRAW_MUL_B,
        S_DRAW_OUT
    } ctrl_state_t;

endpackage

// File: rtl/core/smg_datapath.sv
// datapath of the generator: accumulator, state, shared multiplier and output word
module smg_datapath
    import smg_pkg::*;
(
    input  logic        clk,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  seed_byte,
    output logic [31:0] random_word
);

    logic [7:0]  byte_reg;
    logic [31:0] acc_reg;
    logic [31:0] state_reg;
    logic [31:0] prod_reg;
    logic [31:0] t_reg;
    logic [31:0] word_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_result;
    logic [31:0] fin_hash;
    logic [31:0] temper_sum;
    logic [31:0] temper_mix;

    always_comb
    begin
        unique case (cmd.op)
            DP_ABS_MUL:
            begin
                mul_a = acc_reg ^ {24'd0, byte_reg};
                mul_b = GOLDEN_MUL;
            end
            DP_FIN_MUL_A:
            begin
                mul_a = acc_reg ^ (acc_reg >> 16);
                mul_b = MIX_MUL_A;
            end
            DP_FIN_MUL_B:
            begin
                mul_a = prod_reg ^ (prod_reg >> 13);
                mul_b = MIX_MUL_B;
            end
            DP_DRAW_MUL_A:
            begin
                mul_a = state_reg ^ (state_reg >> 15);
                mul_b = state_reg | 32'd1;
            end
            DP_DRAW_MUL_B:
            begin
                mul_a = prod_reg ^ (prod_reg >> 7);
                mul_b = prod_reg | TEMPER_OR;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = state_reg;
            end
        endcase
    end

    assign mul_result = mul_a * mul_b;
    assign fin_hash   = prod_reg ^ (prod_reg >> 16);
    assign temper_sum = t_reg + prod_reg;
    assign temper_mix = t_reg ^ temper_sum;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= cmd.boot_byte ? BOOT_BYTE : seed_byte;
        end
        unique case (cmd.op)
            DP_ABS_MUL, DP_FIN_MUL_A, DP_FIN_MUL_B, DP_DRAW_MUL_A:
            begin
                prod_reg <= mul_result;
            end
            DP_DRAW_MUL_B:
            begin
                t_reg    <= prod_reg;
                prod_reg <= mul_result;
            end
            DP_ABS_LOAD:
            begin
                acc_reg <= prod_reg ^ (prod_reg >> 15);
            end
            DP_FIN_LOAD:
            begin
                state_reg <= (fin_hash == 32'd0) ? 32'd1 : fin_hash;
                acc_reg   <= 32'd0;
            end
            DP_DRAW_STEP:
            begin
                state_reg <= state_reg + WEYL_STEP;
            end
            DP_DRAW_OUT:
            begin
                word_reg <= temper_mix ^ (temper_mix >> 14);
            end
            default:
            begin
            end
        endcase
    end

    // the accumulator has no reset value; it is cleared by a finish-load command at boot
    assign random_word = word_reg;

endmodule

// File: rtl/core/smg_controller.sv
// controller state machine of the generator: sequencing and handshakes
module smg_controller
    import smg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    output logic       acc_clear
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        boot_reg;
    logic        boot_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        acc_clear      = 1'b0;
        cmd.capture    = 1'b0;
        cmd.boot_byte  = 1'b0;
        cmd.op         = DP_NOP;
        unique case (state_reg)
            S_BOOT:
            begin
                // hash of the seed text "0" before the first beat
                cmd.capture   = 1'b1;
                cmd.boot_byte = 1'b1;
                acc_clear     = 1'b1;
                state_next    = S_ABS_MUL;
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_ABSORB: state_next = S_ABS_MUL;
                        MODE_FINISH: state_next = S_FIN_MUL_A;
                        MODE_DRAW:   state_next = S_DRAW_STEP;
                        MODE_IGNORE: state_next = S_IDLE;
                    endcase
                end
            end
            S_ABS_MUL:
            begin
                cmd.op     = DP_ABS_MUL;
                state_next = S_ABS_LOAD;
            end
            S_ABS_LOAD:
            begin
                cmd.op     = DP_ABS_LOAD;
                state_next = boot_reg ? S_FIN_MUL_A : S_IDLE;
            end
            S_FIN_MUL_A:
            begin
                cmd.op     = DP_FIN_MUL_A;
                state_next = S_FIN_MUL_B;
            end
            S_FIN_MUL_B:
            begin
                cmd.op     = DP_FIN_MUL_B;
                state_next = S_FIN_LOAD;
            end
            S_FIN_LOAD:
            begin
                cmd.op     = DP_FIN_LOAD;
                boot_next  = 1'b0;
                state_next = S_IDLE;
            end
            S_DRAW_STEP:
            begin
                cmd.op     = DP_DRAW_STEP;
                state_next = S_DRAW_MUL_A;
            end
            S_DRAW_MUL_A:
            begin
                cmd.op     = DP_DRAW_MUL_A;
                state_next = S_DRAW_MUL_B;
            end
            S_DRAW_MUL_B:
            begin
                cmd.op     = DP_DRAW_MUL_B;
                state_next = S_DRAW_OUT;
            end
            S_DRAW_OUT:
            begin
                // hold while the previous word is still waiting
                if (!(out_valid_reg && !out_ready))
                begin
                    cmd.op         = DP_DRAW_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/smg_acc_reset.sv
// reset-cleared guard on the accumulator used by the boot hash
module smg_acc_reset
    import smg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    acc_clear,
    input  dp_cmd_t cmd_in,
    output dp_cmd_t cmd_out
);

    logic cleared_reg;
    logic cleared_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cleared_reg <= 1'b0;
        end
        else
        begin
            cleared_reg <= cleared_next;
        end
    end

    assign cleared_next = cleared_reg || acc_clear;

    // on the boot beat the accumulator is zeroed through the finish-load path
    always_comb
    begin
        cmd_out = cmd_in;
        if (acc_clear && !cleared_reg)
        begin
            cmd_out.op = DP_FIN_LOAD;
        end
    end

endmodule

// File: rtl/core/seeded_mulberry32_generator_unit.sv
// top level of the seeded mulberry32 generator
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode[1:0], seed_byte[7:0]
// out       output     out_valid / out_ready  random_word[31:0]
//
// one beat at a time: absorb, finish and draw step through their states; an ignored mode stays idle
// the multiply steps share the one 32x32 multiplier, one product per cycle
// after reset the unit hashes the seed text "0" with in_ready low
// a finished word waits in the output register; a new beat is taken meanwhile
// and a following draw holds in its last step until that word is taken
module seeded_mulberry32_generator_unit
    import smg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  seed_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    dp_cmd_t ctrl_cmd;
    dp_cmd_t dp_cmd;
    logic    acc_clear;

    smg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (ctrl_cmd),
        .acc_clear (acc_clear)
    );

    smg_acc_reset u_acc_reset (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_clear (acc_clear),
        .cmd_in    (ctrl_cmd),
        .cmd_out   (dp_cmd)
    );

    smg_datapath u_dp (
        .clk         (clk),
        .cmd         (dp_cmd),
        .seed_byte   (seed_byte),
        .random_word (random_word)
    );

endmodule

// File: rtl/core/smg_checker.sv
// port-level assertions for the generator and their binding
module smg_checker
    import smg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] random_word
);

    // a draw taken with nothing pending shows its word after the step, both multiply and output states
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_DRAW && !out_valid) |-> ##5 out_valid)
        else $error("draw word not presented on time");

    // a new word appears only as the unit returns to taking beats
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("word presented while busy");

    // absorb, finish and draw beats keep the unit busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_ABSORB || mode == MODE_DRAW
            || mode == MODE_FINISH)) |=> !in_ready)
        else $error("beat taken while previous one in work");

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(random_word)))
        else $error("stalled word changed");

endmodule

bind seeded_mulberry32_generator_unit smg_checker u_smg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word)
);
